FILE: rtl/sfd_pkg.sv
// Shared types, constants and helpers for the stereo feedback delay.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int DLY_W       = 17;
  localparam int GAIN_W      = 17;
  localparam int DLY_RESET   = 24000;

  localparam logic [GAIN_W-1:0] UNITY      = 17'h10000;
  localparam logic [GAIN_W-1:0] WET_RESET  = 17'h08000;
  localparam logic [GAIN_W-1:0] FB_RESET   = 17'h00000;

  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_DELAY    = 2'd1,
    REG_FEEDBACK = 2'd2,
    REG_WET_MIX  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } frame_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } frame_out_t;

  // Control from the shared sequencer to each channel lane.
  typedef struct packed {
    logic adv;
    logic wr_en;
    logic clr;
    logic fwd_s2;
    logic fwd_lw;
    logic bypass;
  } lane_ctl_t;

  // Saturate a sum that carries three guard bits down to one sample.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
      input logic signed [SAMPLE_BITS+2:0] v);
    logic [3:0] top;
    top = v[SAMPLE_BITS+2:SAMPLE_BITS-1];
    if (top == 4'b0000 || top == 4'b1111) begin
      sat_smp = v[SAMPLE_BITS-1:0];
    end else if (v[SAMPLE_BITS+2]) begin
      sat_smp = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_smp = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sfd_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
`timescale 1ns / 1ps
`default_nettype none

module sfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/sfd_dly_mod.sv
// Reduction of the delay register modulo the store depth by reciprocal multiplication.
`timescale 1ns / 1ps
`default_nettype none

module sfd_dly_mod import sfd_pkg::*; #(
  parameter int STORE_DEPTH = 131072,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DLY_W-1:0] value_i,
  output logic                  busy_o,
  output logic      [AW-1:0]    dly_o
);

  // The reciprocal is rounded up with DLY_W + AW fraction bits, which makes
  // the quotient exact for every DLY_W-bit value.
  localparam int     SH    = DLY_W + AW;
  localparam int     MW    = DLY_W + 2;
  localparam int     PW    = DLY_W + MW;
  localparam int     EW    = DLY_W + AW + 1;
  localparam longint RECIP = ((64'sd1 <<< SH) + STORE_DEPTH - 1) / STORE_DEPTH;
  localparam logic [PW-1:0] RECIP_M = PW'(RECIP);
  localparam logic [EW-1:0] DEPTH_E = EW'(STORE_DEPTH);
  localparam logic [AW-1:0] DLY_RST = AW'(DLY_RESET % STORE_DEPTH);

  logic              busy_q, busy_d;
  logic              ph_q, ph_d;
  logic [DLY_W-1:0]  val_q, val_d;
  logic [DLY_W-1:0]  quo_q, quo_d;
  logic [AW-1:0]     dly_q, dly_d;
  logic [PW-1:0]     prod;
  logic [EW-1:0]     qd, rem;

  assign prod = PW'(val_q) * RECIP_M;
  assign qd   = EW'(quo_q) * DEPTH_E;
  assign rem  = EW'(val_q) - qd;

  // Phase 0 forms the quotient, phase 1 the remainder.
  always_comb begin
    busy_d = busy_q;
    ph_d   = ph_q;
    val_d  = val_q;
    quo_d  = quo_q;
    dly_d  = dly_q;
    if (start_i) begin
      busy_d = 1'b1;
      ph_d   = 1'b0;
      val_d  = value_i;
    end else if (busy_q) begin
      if (!ph_q) begin
        quo_d = DLY_W'(prod >> SH);
        ph_d  = 1'b1;
      end else begin
        dly_d  = rem[AW-1:0];
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
      dly_q  <= DLY_RST;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
      dly_q  <= dly_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign dly_o  = dly_q;

endmodule

`default_nettype wire

FILE: rtl/sfd_lane.sv
// One channel lane: circular store, feedback and mix datapath with forwarding.
`timescale 1ns / 1ps
`default_nettype none

module sfd_lane import sfd_pkg::*; #(
  parameter int STORE_DEPTH = 131072,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire lane_ctl_t                     ctl_i,
  input  wire logic        [AW-1:0]          rd_addr_i,
  input  wire logic        [AW-1:0]          wr_addr_i,
  input  wire logic signed [SAMPLE_BITS-1:0] x_i,
  input  wire logic        [GAIN_W-1:0]      fb_gain_i,
  input  wire logic        [GAIN_W-1:0]      wet_mix_i,
  output logic signed      [SAMPLE_BITS-1:0] y_o
);

  localparam int SW    = SAMPLE_BITS;
  localparam int PW    = SW + GAIN_W + 1;
  localparam int SUM_W = SW + 3;

  logic        [SW-1:0]    ram_rdata;
  logic        [SW-1:0]    ram_wdata;
  logic signed [SW-1:0]    x1_q, x2_q;
  logic signed [SW-1:0]    lw_q;
  logic signed [SW-1:0]    d_sel;
  logic        [GAIN_W-1:0] dry_gain;
  logic signed [PW-1:0]    p_fb_d, p_wet_d, p_dry_d;
  logic signed [PW-1:0]    p_fb_q, p_wet_q, p_dry_q;
  logic signed [SW+1:0]    fb_sh, wet_sh, dry_sh;
  logic signed [SUM_W-1:0] fb_sum, mix_sum;
  logic signed [SW-1:0]    wdata, ymix;

  assign ram_wdata = ctl_i.clr ? '0 : wdata;

  sfd_ram #(
    .WIDTH(SW),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ctl_i.wr_en),
    .waddr_i(wr_addr_i),
    .wdata_i(ram_wdata),
    .re_i   (ctl_i.adv),
    .raddr_i(rd_addr_i),
    .rdata_o(ram_rdata)
  );

  // The frame one stage ahead has not reached the store yet, and the one
  // written at the read edge was missed by the read-first port.
  always_comb begin
    if (ctl_i.fwd_s2) begin
      d_sel = wdata;
    end else if (ctl_i.fwd_lw) begin
      d_sel = lw_q;
    end else begin
      d_sel = ram_rdata;
    end
  end

  assign dry_gain = UNITY - wet_mix_i;
  assign p_fb_d   = d_sel * $signed({1'b0, fb_gain_i});
  assign p_wet_d  = d_sel * $signed({1'b0, wet_mix_i});
  assign p_dry_d  = x1_q * $signed({1'b0, dry_gain});

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      x1_q    <= x_i;
      x2_q    <= x1_q;
      p_fb_q  <= p_fb_d;
      p_wet_q <= p_wet_d;
      p_dry_q <= p_dry_d;
      lw_q    <= wdata;
    end
  end

  assign fb_sh   = p_fb_q[PW-1:GAIN_W-1];
  assign wet_sh  = p_wet_q[PW-1:GAIN_W-1];
  assign dry_sh  = p_dry_q[PW-1:GAIN_W-1];
  assign fb_sum  = SUM_W'(x2_q) + SUM_W'(fb_sh);
  assign mix_sum = SUM_W'(dry_sh) + SUM_W'(wet_sh);
  assign wdata   = sat_smp(fb_sum);
  assign ymix    = sat_smp(mix_sum);
  assign y_o     = ctl_i.bypass ? x2_q : ymix;

endmodule

`default_nettype wire

FILE: rtl/stereo_feedback_delay.sv
// Stereo feedback delay: two channel lanes, shared write pointer and control.
// Pipeline: a frame passes the s1 and s2 stages and then the output register.
// Throughput: one frame per cycle, limited by the one read and one write
// port of each channel store; a stalled output holds the whole pipeline.
// Reset: a clearing pass writes zeros over every store entry with in_ready_o
// low; a delay write holds in_ready_o low while the delay is reduced.
`timescale 1ns / 1ps
`default_nettype none

module stereo_feedback_delay import sfd_pkg::*; #(
  parameter int STORE_DEPTH = 131072
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire frame_in_t  in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output frame_out_t      out_data_o,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(STORE_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(STORE_DEPTH);

  // Configuration registers.
  logic              enable_q;
  logic [DLY_W-1:0]  delay_q;
  logic [GAIN_W-1:0] fb_q, wet_q;
  logic              cfg_wr, dly_start;
  reg_idx_e          cfg_idx;
  logic [GAIN_W-1:0] fb_clamp, wet_clamp;

  // Sequencing.
  logic              dm_busy;
  logic [AW-1:0]     dly;
  logic              clr_busy_q, clr_busy_d;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [AW:0]       rd_wrap;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              adv, accept;
  logic              s1_valid_q, s2_valid_q, lw_valid_q, out_valid_q;
  logic [AW-1:0]     s1_rd_q, s1_wp_q, s2_wp_q, lw_wp_q;
  lane_ctl_t         ctl;
  logic signed [SAMPLE_BITS-1:0] y_left, y_right;
  frame_out_t        out_q;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign dly_start = cfg_wr && (cfg_idx == REG_DELAY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      delay_q  <= DLY_W'(DLY_RESET);
      fb_q     <= FB_RESET;
      wet_q    <= WET_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENABLE:   enable_q <= pwdata[0];
        REG_DELAY:    delay_q  <= pwdata[DLY_W-1:0];
        REG_FEEDBACK: fb_q     <= pwdata[GAIN_W-1:0];
        REG_WET_MIX:  wet_q    <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENABLE:   prdata = {31'b0, enable_q};
      REG_DELAY:    prdata = 32'(delay_q);
      REG_FEEDBACK: prdata = 32'(fb_q);
      REG_WET_MIX:  prdata = 32'(wet_q);
      default:      prdata = '0;
    endcase
  end

  assign fb_clamp  = (fb_q > UNITY) ? UNITY : fb_q;
  assign wet_clamp = (wet_q > UNITY) ? UNITY : wet_q;

  sfd_dly_mod #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dly_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dly_start),
    .value_i(pwdata[DLY_W-1:0]),
    .busy_o (dm_busy),
    .dly_o  (dly)
  );

  // The pipeline moves as a whole whenever the output register can take data.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv && !clr_busy_q && !dm_busy;
  assign accept     = in_valid_i && in_ready_o;

  assign rd_wrap = {1'b0, wp_q} + DEPTH_X - {1'b0, dly};
  assign rd_addr = (wp_q >= dly) ? (wp_q - dly) : rd_wrap[AW-1:0];

  always_comb begin
    wp_d = wp_q;
    if (accept && enable_q) begin
      wp_d = (wp_q == LAST) ? '0 : wp_q + 1'b1;
    end
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      if (clr_cnt_q == LAST) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      lw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q       <= wp_d;
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
      if (adv) begin
        s1_valid_q  <= accept;
        s2_valid_q  <= s1_valid_q;
        lw_valid_q  <= s2_valid_q && enable_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_rd_q <= rd_addr;
      s1_wp_q <= wp_q;
      s2_wp_q <= s1_wp_q;
      lw_wp_q <= s2_wp_q;
      out_q   <= '{left_out: y_left, right_out: y_right};
    end
  end

  assign wr_addr    = clr_busy_q ? clr_cnt_q : s2_wp_q;
  assign ctl.adv    = adv;
  assign ctl.clr    = clr_busy_q;
  assign ctl.wr_en  = clr_busy_q || (adv && s2_valid_q && enable_q);
  assign ctl.fwd_s2 = s2_valid_q && enable_q && (s2_wp_q == s1_rd_q);
  assign ctl.fwd_lw = lw_valid_q && (lw_wp_q == s1_rd_q);
  assign ctl.bypass = !enable_q;

  sfd_lane #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_lane_left (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .x_i      (in_data_i.left_in),
    .fb_gain_i(fb_clamp),
    .wet_mix_i(wet_clamp),
    .y_o      (y_left)
  );

  sfd_lane #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_lane_right (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .x_i      (in_data_i.right_in),
    .fb_gain_i(fb_clamp),
    .wet_mix_i(wet_clamp),
    .y_o      (y_right)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
